[design/pws_pkg.sv]
`default_nettype none
package pws_pkg;

	localparam int COORD_W = 24;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_MEAN = 2'd1;
	localparam logic [1:0] MODE_TRIM = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] filt_x;
		logic signed [COORD_W-1:0] filt_y;
		logic signed [COORD_W-1:0] filt_z;
		logic filt_ready;
	} filt_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic acc;
		logic first;
		logic load;
		logic step;
		logic trim;
	} axis_ctrl_t;

endpackage
`default_nettype wire

[design/pws_axis.sv]
`default_nettype none
module pws_axis #(
	parameter int WINDOW_LEN = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire pws_pkg::axis_ctrl_t ctrl,
	input wire logic signed [pws_pkg::COORD_W-1:0] sample,
	output logic signed [pws_pkg::COORD_W-1:0] result
);

	localparam int CW = pws_pkg::COORD_W;
	localparam int IW = $clog2(WINDOW_LEN);
	localparam int SW = CW + IW + 1;
	localparam int RW = IW + 2;
	localparam logic [RW-1:0] DIV_MEAN = RW'(WINDOW_LEN);
	localparam logic [RW-1:0] DIV_TRIM = RW'(WINDOW_LEN - 2);

	logic signed [CW-1:0] win_q [WINDOW_LEN];
	logic signed [SW-1:0] sum_q;
	logic signed [CW-1:0] hi_q;
	logic signed [CW-1:0] lo_q;
	logic [SW-1:0] mag_q;
	logic [RW-1:0] rem_q;
	logic neg_q;

	logic signed [CW-1:0] elem;
	logic signed [SW-1:0] elem_ext;
	logic signed [SW-1:0] hi_ext;
	logic signed [SW-1:0] lo_ext;
	logic signed [SW-1:0] total;
	logic [RW-1:0] divisor;
	logic [RW-1:0] rem_sh;
	logic [SW-1:0] quot;

	assign elem = win_q[0];
	assign elem_ext = signed'({{(SW-CW){elem[CW-1]}}, elem});
	assign hi_ext = signed'({{(SW-CW){hi_q[CW-1]}}, hi_q});
	assign lo_ext = signed'({{(SW-CW){lo_q[CW-1]}}, lo_q});
	assign total = ctrl.trim ? (sum_q - hi_ext - lo_ext) : sum_q;
	assign divisor = ctrl.trim ? DIV_TRIM : DIV_MEAN;
	assign rem_sh = {rem_q[RW-2:0], mag_q[SW-1]};
	assign quot = neg_q ? (~mag_q + SW'(1)) : mag_q;
	assign result = signed'(quot[CW-1:0]);

	// window is a shift line, oldest at index 0; a full rotation restores it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (ctrl.shift || ctrl.acc) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_LEN-1] <= ctrl.shift ? sample : win_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			if (ctrl.first) begin
				sum_q <= elem_ext;
				hi_q <= elem;
				lo_q <= elem;
			end else begin
				sum_q <= sum_q + elem_ext;
				if (elem > hi_q) begin
					hi_q <= elem;
				end
				if (elem < lo_q) begin
					lo_q <= elem;
				end
			end
		end
		if (ctrl.load) begin
			neg_q <= total[SW-1];
			mag_q <= total[SW-1] ? unsigned'(-total) : unsigned'(total);
			rem_q <= '0;
		end else if (ctrl.step) begin
			// restoring division, one quotient bit per cycle
			if (rem_sh >= divisor) begin
				rem_q <= rem_sh - divisor;
				mag_q <= {mag_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				mag_q <= {mag_q[SW-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

[design/position_window_smoother.sv]
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | in_data  (pws_pkg::pos_t)
// out     | out of    | out_valid/out_stall| out_data (pws_pkg::filt_t)
// cfg     | into      | cfg_we             | cfg_data (filter_mode)
// A filtered report is taken in, makes one pass over the window per axis, loads
// the divider and then gets one quotient bit per cycle from the serial divider.
// A report that does not filter goes from intake straight to the output stage.
// One report is in flight at a time; the output register holds a finished beat
// under stall while the next report is worked on, and that report's beat waits
// until the register drains.
// Reset clears window, counters, held values and mode; no clearing pass.
`default_nettype none
module position_window_smoother #(
	parameter int WINDOW_LEN = 8,
	parameter int HISTORY_LEN = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire pws_pkg::pos_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output pws_pkg::filt_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_data
);

	localparam int CW = pws_pkg::COORD_W;
	localparam int IW = $clog2(WINDOW_LEN);
	localparam int SW = CW + IW + 1;
	localparam int NW = $clog2(WINDOW_LEN + SW);
	localparam int FW = $clog2(HISTORY_LEN);

	pws_pkg::state_t state_q, state_d;
	logic [NW-1:0] cnt_q, cnt_d;
	logic [FW-1:0] fill_q;
	logic [FW:0] fill_inc;
	logic ready_q;
	logic ready_next;
	logic [1:0] mode_q;
	logic trim_q;
	logic active_q;
	logic active_now;
	logic accept;
	logic emit;
	logic out_valid_q;
	pws_pkg::filt_t out_q;
	logic signed [CW-1:0] held_x_q, held_y_q, held_z_q;
	logic signed [CW-1:0] res_x, res_y, res_z;
	pws_pkg::axis_ctrl_t ctrl;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != pws_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign fill_inc = {1'b0, fill_q} + (FW+1)'(1);
	assign ready_next = ready_q || (fill_inc >= (FW+1)'(HISTORY_LEN));
	assign active_now = ready_next &&
		(mode_q == pws_pkg::MODE_MEAN || mode_q == pws_pkg::MODE_TRIM);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		emit = 1'b0;
		ctrl = '0;
		ctrl.trim = trim_q;
		unique case (state_q)
			pws_pkg::S_IDLE: begin
				if (accept) begin
					ctrl.shift = 1'b1;
					cnt_d = '0;
					state_d = active_now ? pws_pkg::S_ACC : pws_pkg::S_DONE;
				end
			end
			pws_pkg::S_ACC: begin
				ctrl.acc = 1'b1;
				ctrl.first = (cnt_q == '0);
				cnt_d = cnt_q + NW'(1);
				if (cnt_q == NW'(WINDOW_LEN - 1)) begin
					state_d = pws_pkg::S_LOAD;
				end
			end
			pws_pkg::S_LOAD: begin
				ctrl.load = 1'b1;
				cnt_d = '0;
				state_d = pws_pkg::S_DIV;
			end
			pws_pkg::S_DIV: begin
				ctrl.step = 1'b1;
				cnt_d = cnt_q + NW'(1);
				if (cnt_q == NW'(SW - 1)) begin
					state_d = pws_pkg::S_DONE;
				end
			end
			pws_pkg::S_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || !out_stall) begin
					emit = 1'b1;
					state_d = pws_pkg::S_IDLE;
				end
			end
			default: state_d = pws_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pws_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pws_pkg::MODE_NONE;
			fill_q <= '0;
			ready_q <= 1'b0;
			trim_q <= 1'b0;
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
			held_z_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				fill_q <= (fill_inc >= (FW+1)'(HISTORY_LEN)) ? '0 : fill_inc[FW-1:0];
				ready_q <= ready_next;
				trim_q <= (mode_q == pws_pkg::MODE_TRIM);
				active_q <= active_now;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (active_q) begin
					held_x_q <= res_x;
					held_y_q <= res_y;
					held_z_q <= res_z;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.filt_x <= active_q ? res_x : held_x_q;
			out_q.filt_y <= active_q ? res_y : held_y_q;
			out_q.filt_z <= active_q ? res_z : held_z_q;
			out_q.filt_ready <= active_q;
		end
	end

	pws_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_x (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(in_data.pos_x), .result(res_x)
	);
	pws_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_y (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(in_data.pos_y), .result(res_y)
	);
	pws_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_z (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(in_data.pos_z), .result(res_z)
	);

endmodule
`default_nettype wire

[design/pws_checker.sv]
`default_nettype none
module pws_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire pws_pkg::filt_t out_data
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// one report at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a report is in flight");

	// a result only appears out of a report in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without a report in flight");

endmodule

bind position_window_smoother pws_checker u_pws_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
